// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse raster core.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_RADIUS_X = 2'd0;
    localparam logic [1:0] REG_RADIUS_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_X = 2'd2;
    localparam logic [1:0] REG_CENTER_Y = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_MUL,
        S_INIT_LOAD,
        S_EVAL,
        S_UPD2,
        S_RC1,
        S_RC2,
        S_RC3,
        S_RC4,
        S_RC5,
        S_RC6
    } t_state;

    typedef enum logic [1:0] {
        MUL_A_RX2,
        MUL_A_RY2,
        MUL_A_PROD
    } t_mul_a;

    typedef enum logic [1:0] {
        MUL_B_RY,
        MUL_B_TX,
        MUL_B_ATY,
        MUL_B_RY2
    } t_mul_b;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD4,
        ACC_SUB4
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        t_acc_op acc_op;
        logic    load_init;
        logic    upd1;
        logic    upd2;
        logic    set_r2;
        logic    set_done;
        logic    emit_pts;
        logic    emit_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
        logic region_two;
        logic gx_lt_gy;
        logic y_neg;
    } t_dp_stat;

endpackage

// ===== rtl/mer_regs.sv =====
// ----------------------------------------------------------------------------
// mer_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module mer_regs #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mer_pkg::PADDR_W-1:0]     paddr,
    input  logic [mer_pkg::PDATA_W-1:0]     pwdata,
    output logic [mer_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output logic [RADIUS_BITS-1:0]          o_radius_x,
    output logic [RADIUS_BITS-1:0]          o_radius_y,
    output logic signed [COORD_BITS-1:0]    o_center_x,
    output logic signed [COORD_BITS-1:0]    o_center_y
);
    import mer_pkg::*;

    logic [RADIUS_BITS-1:0] r_radius_x;
    logic [RADIUS_BITS-1:0] r_radius_y;
    logic [COORD_BITS-1:0]  r_center_x;
    logic [COORD_BITS-1:0]  r_center_y;
    logic                   wr_en;
    logic [1:0]             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_x <= '0;
            r_radius_y <= '0;
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RADIUS_X: r_radius_x <= pwdata[RADIUS_BITS-1:0];
                REG_RADIUS_Y: r_radius_y <= pwdata[RADIUS_BITS-1:0];
                REG_CENTER_X: r_center_x <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RADIUS_X: prdata = {{(PDATA_W-RADIUS_BITS){1'b0}}, r_radius_x};
            REG_RADIUS_Y: prdata = {{(PDATA_W-RADIUS_BITS){1'b0}}, r_radius_y};
            REG_CENTER_X: prdata = {{(PDATA_W-COORD_BITS){1'b0}}, r_center_x};
            REG_CENTER_Y: prdata = {{(PDATA_W-COORD_BITS){1'b0}}, r_center_y};
            default:      prdata = '0;
        endcase
    end

    assign o_radius_x = r_radius_x;
    assign o_radius_y = r_radius_y;
    assign o_center_x = $signed(r_center_x);
    assign o_center_y = $signed(r_center_y);

endmodule

// ===== rtl/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// mer_ctrl
// Step sequencer: accepts step requests and drives the datapath commands.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_restart,
    output logic              o_ready,
    input  mer_pkg::t_dp_stat i_stat,
    input  logic              i_emit_free,
    output mer_pkg::t_dp_cmd  o_cmd
);
    import mer_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_restart ? S_INIT_MUL : S_EVAL;
                end
            end
            S_INIT_MUL:  n_state = S_INIT_LOAD;
            S_INIT_LOAD: n_state = S_EVAL;
            S_EVAL: begin
                if (i_stat.walk_done) begin
                    if (i_emit_free) begin
                        n_state = S_IDLE;
                    end
                end else if (!i_stat.region_two && !i_stat.gx_lt_gy) begin
                    n_state = S_RC1;
                end else if (i_stat.region_two && i_stat.y_neg) begin
                    if (i_emit_free) begin
                        n_state = S_IDLE;
                    end
                end else if (i_emit_free) begin
                    n_state = S_UPD2;
                end
            end
            S_UPD2: n_state = S_IDLE;
            S_RC1:  n_state = S_RC2;
            S_RC2:  n_state = S_RC3;
            S_RC3:  n_state = S_RC4;
            S_RC4:  n_state = S_RC5;
            S_RC5:  n_state = S_RC6;
            S_RC6:  n_state = S_EVAL;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_INIT_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MUL_A_RX2;
                o_cmd.mul_b  = MUL_B_RY;
            end
            S_INIT_LOAD: o_cmd.load_init = 1'b1;
            S_EVAL: begin
                if (i_stat.walk_done) begin
                    o_cmd.emit_fin = i_emit_free;
                end else if (!i_stat.region_two && !i_stat.gx_lt_gy) begin
                    o_cmd = '0;
                end else if (i_stat.region_two && i_stat.y_neg) begin
                    o_cmd.emit_fin = i_emit_free;
                    o_cmd.set_done = i_emit_free;
                end else begin
                    o_cmd.emit_pts = i_emit_free;
                    o_cmd.upd1     = i_emit_free;
                end
            end
            S_UPD2: o_cmd.upd2 = 1'b1;
            S_RC1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MUL_A_RY2;
                o_cmd.mul_b  = MUL_B_TX;
            end
            S_RC2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MUL_A_PROD;
                o_cmd.mul_b  = MUL_B_TX;
            end
            S_RC3: begin
                o_cmd.acc_op = ACC_LOAD;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MUL_A_RX2;
                o_cmd.mul_b  = MUL_B_ATY;
            end
            S_RC4: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MUL_A_PROD;
                o_cmd.mul_b  = MUL_B_ATY;
            end
            S_RC5: begin
                o_cmd.acc_op = ACC_ADD4;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MUL_A_RX2;
                o_cmd.mul_b  = MUL_B_RY2;
            end
            S_RC6: begin
                o_cmd.acc_op = ACC_SUB4;
                o_cmd.set_r2 = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/mer_dpath.sv =====
// ----------------------------------------------------------------------------
// mer_dpath
// Walk state, gradient and decision terms, and the shared multiplier.
// ----------------------------------------------------------------------------
module mer_dpath #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [RADIUS_BITS-1:0]       i_radius_x,
    input  logic [RADIUS_BITS-1:0]       i_radius_y,
    input  mer_pkg::t_dp_cmd             i_cmd,
    output mer_pkg::t_dp_stat            o_stat,
    output logic [RADIUS_BITS:0]         o_step_x,
    output logic [RADIUS_BITS+1:0]       o_step_y
);
    import mer_pkg::*;

    localparam int XW  = RADIUS_BITS + 1;
    localparam int YW  = RADIUS_BITS + 2;
    localparam int GW  = 3 * RADIUS_BITS + 3;
    localparam int DW  = 4 * RADIUS_BITS + 6;
    localparam int SQW = 2 * RADIUS_BITS;
    localparam int MA  = 3 * RADIUS_BITS + 2;
    localparam int MB  = 2 * RADIUS_BITS;
    localparam int PW  = 4 * RADIUS_BITS + 4;

    logic [SQW-1:0]   r_rx2;
    logic [SQW-1:0]   r_ry2;
    logic [PW-1:0]    r_prod;
    logic [XW-1:0]    r_x,  n_x;
    logic [YW-1:0]    r_y,  n_y;
    logic [GW-1:0]    r_gx, n_gx;
    logic [GW-1:0]    r_gy, n_gy;
    logic [DW-1:0]    r_d,  n_d;
    logic             r_r2, n_r2;
    logic             r_done, n_done;
    logic             r_use_gx, n_use_gx;
    logic             r_use_gy, n_use_gy;

    logic [MA-1:0]    mul_a;
    logic [MB-1:0]    mul_b;
    logic [MA+MB-1:0] mul_full;
    logic [XW:0]      tx;
    logic [YW-1:0]    ty;
    logic [YW-1:0]    aty;
    logic [GW-1:0]    gx_inc;
    logic [GW-1:0]    gy_dec;
    logic [DW-1:0]    prod_d;
    logic [DW-1:0]    rx2_d;
    logic [DW-1:0]    ry2_d;
    logic [DW-1:0]    gx_d;
    logic [DW-1:0]    gy_d;
    logic [DW-1:0]    term_gx;
    logic [DW-1:0]    term_gy;
    logic [DW-1:0]    term_k;
    logic             d_neg;
    logic             d_pos;

    always_ff @(posedge i_clk) begin
        r_rx2 <= SQW'(i_radius_x) * SQW'(i_radius_x);
        r_ry2 <= SQW'(i_radius_y) * SQW'(i_radius_y);
        if (i_cmd.mul_en) begin
            r_prod <= mul_full[PW-1:0];
        end
    end

    assign tx  = {r_x, 1'b1};
    assign ty  = r_y - YW'(1);
    assign aty = ty[YW-1] ? (YW'(0) - ty) : ty;

    always_comb begin
        case (i_cmd.mul_a)
            MUL_A_RX2:  mul_a = MA'(r_rx2);
            MUL_A_RY2:  mul_a = MA'(r_ry2);
            MUL_A_PROD: mul_a = r_prod[MA-1:0];
            default:    mul_a = '0;
        endcase
        case (i_cmd.mul_b)
            MUL_B_RY:  mul_b = MB'(i_radius_y);
            MUL_B_TX:  mul_b = MB'(tx);
            MUL_B_ATY: mul_b = MB'(aty);
            MUL_B_RY2: mul_b = r_ry2;
            default:   mul_b = '0;
        endcase
    end

    assign mul_full = {{MB{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};

    assign gx_inc  = {{(GW-SQW-1){1'b0}}, r_ry2, 1'b0};
    assign gy_dec  = {{(GW-SQW-1){1'b0}}, r_rx2, 1'b0};
    assign prod_d  = {{(DW-PW){1'b0}}, r_prod};
    assign rx2_d   = {{(DW-SQW){1'b0}}, r_rx2};
    assign ry2_d   = {{(DW-SQW){1'b0}}, r_ry2};
    assign gx_d    = {{(DW-GW){r_gx[GW-1]}}, r_gx};
    assign gy_d    = {{(DW-GW){r_gy[GW-1]}}, r_gy};
    assign term_gx = r_use_gx ? {gx_d[DW-3:0], 2'b00} : '0;
    assign term_gy = r_use_gy ? {gy_d[DW-3:0], 2'b00} : '0;
    assign term_k  = r_r2 ? {rx2_d[DW-3:0], 2'b00} : {ry2_d[DW-3:0], 2'b00};
    assign d_neg   = r_d[DW-1];
    assign d_pos   = !r_d[DW-1] && (r_d != '0);

    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_gx     = r_gx;
        n_gy     = r_gy;
        n_d      = r_d;
        n_r2     = r_r2;
        n_done   = r_done;
        n_use_gx = r_use_gx;
        n_use_gy = r_use_gy;

        case (i_cmd.acc_op)
            ACC_LOAD: n_d = prod_d;
            ACC_ADD4: n_d = r_d + {prod_d[DW-3:0], 2'b00};
            ACC_SUB4: n_d = r_d - {prod_d[DW-3:0], 2'b00};
            default: ;
        endcase

        if (i_cmd.load_init) begin
            n_x    = '0;
            n_y    = {2'b00, i_radius_y};
            n_gx   = '0;
            n_gy   = {r_prod[GW-2:0], 1'b0};
            n_d    = {ry2_d[DW-3:0], 2'b00} - {prod_d[DW-3:0], 2'b00} + rx2_d;
            n_r2   = 1'b0;
            n_done = 1'b0;
        end

        if (i_cmd.upd1) begin
            if (!r_r2) begin
                n_x      = r_x + XW'(1);
                n_gx     = r_gx + gx_inc;
                n_use_gx = 1'b1;
                n_use_gy = !d_neg;
                if (!d_neg) begin
                    n_y  = r_y - YW'(1);
                    n_gy = r_gy - gy_dec;
                end
            end else begin
                n_y      = r_y - YW'(1);
                n_gy     = r_gy - gy_dec;
                n_use_gx = !d_pos;
                n_use_gy = 1'b1;
                if (!d_pos) begin
                    n_x  = r_x + XW'(1);
                    n_gx = r_gx + gx_inc;
                end
            end
        end

        if (i_cmd.upd2) begin
            n_d = r_d + term_gx - term_gy + term_k;
        end

        if (i_cmd.set_r2) begin
            n_r2 = 1'b1;
        end
        if (i_cmd.set_done) begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_gx     <= '0;
            r_gy     <= '0;
            r_d      <= '0;
            r_r2     <= 1'b0;
            r_done   <= 1'b1;
            r_use_gx <= 1'b0;
            r_use_gy <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_gx     <= n_gx;
            r_gy     <= n_gy;
            r_d      <= n_d;
            r_r2     <= n_r2;
            r_done   <= n_done;
            r_use_gx <= n_use_gx;
            r_use_gy <= n_use_gy;
        end
    end

    assign o_stat.walk_done  = r_done;
    assign o_stat.region_two = r_r2;
    assign o_stat.gx_lt_gy   = $signed(r_gx) < $signed(r_gy);
    assign o_stat.y_neg      = r_y[YW-1];
    assign o_step_x          = r_x;
    assign o_step_y          = r_y;

endmodule

// ===== rtl/mer_emit.sv =====
// ----------------------------------------------------------------------------
// mer_emit
// Output stage: sends the four mirrored points or the finished beat.
// ----------------------------------------------------------------------------
module mer_emit #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mer_pkg::t_dp_cmd              i_cmd,
    input  logic [RADIUS_BITS:0]          i_step_x,
    input  logic [RADIUS_BITS+1:0]        i_step_y,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic signed [COORD_BITS:0]    o_pixel_x,
    output logic signed [COORD_BITS:0]    o_pixel_y,
    output logic                          o_last,
    output logic                          o_finished,
    output logic                          o_free
);
    import mer_pkg::*;

    localparam int XW = RADIUS_BITS + 1;
    localparam int YW = RADIUS_BITS + 2;
    localparam int SW = ((COORD_BITS > YW) ? COORD_BITS : YW) + 1;

    logic          r_valid, n_valid;
    logic [1:0]    r_cnt,   n_cnt;
    logic          r_fin,   n_fin;
    logic [XW-1:0] r_bx;
    logic [YW-1:0] r_by;
    logic          is_last;
    logic [SW-1:0] cx_e;
    logic [SW-1:0] cy_e;
    logic [SW-1:0] bx_e;
    logic [SW-1:0] by_e;
    logic [SW-1:0] sum_x;
    logic [SW-1:0] sum_y;

    assign is_last = r_fin || (r_cnt == 2'd3);
    assign o_free  = !r_valid || (i_ready && is_last);

    always_comb begin
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_fin   = r_fin;
        if (i_cmd.emit_pts) begin
            n_valid = 1'b1;
            n_cnt   = 2'd0;
            n_fin   = 1'b0;
        end else if (i_cmd.emit_fin) begin
            n_valid = 1'b1;
            n_cnt   = 2'd0;
            n_fin   = 1'b1;
        end else if (r_valid && i_ready) begin
            if (is_last) begin
                n_valid = 1'b0;
            end else begin
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 2'd0;
            r_fin   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pts) begin
            r_bx <= i_step_x;
            r_by <= i_step_y;
        end
    end

    assign cx_e  = {{(SW-COORD_BITS){i_center_x[COORD_BITS-1]}}, i_center_x};
    assign cy_e  = {{(SW-COORD_BITS){i_center_y[COORD_BITS-1]}}, i_center_y};
    assign bx_e  = {{(SW-XW){1'b0}}, r_bx};
    assign by_e  = {{(SW-YW){r_by[YW-1]}}, r_by};
    assign sum_x = r_cnt[0] ? (cx_e - bx_e) : (cx_e + bx_e);
    assign sum_y = r_cnt[1] ? (cy_e - by_e) : (cy_e + by_e);

    assign o_valid    = r_valid;
    assign o_pixel_x  = r_fin ? '0 : $signed(sum_x[COORD_BITS:0]);
    assign o_pixel_y  = r_fin ? '0 : $signed(sum_y[COORD_BITS:0]);
    assign o_last     = is_last;
    assign o_finished = r_fin;

endmodule

// ===== rtl/midpoint_ellipse_raster_core.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_raster_core
// A drawing step waits in the evaluate state until the output stage is free;
// restart first runs the init multiply and load states, and the change to region
// two runs the region-change states around the multiplier. Each step sends four
// beats, one per cycle while the sink is ready; the next step can be accepted
// meanwhile. Reset is synchronous and active low; then the walk counts as ended.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster_core #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_BITS:0]    o_pixel_x,
    output logic signed [COORD_BITS:0]    o_pixel_y,
    output logic                          o_last,
    output logic                          o_finished,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mer_pkg::PADDR_W-1:0]   paddr,
    input  logic [mer_pkg::PDATA_W-1:0]   pwdata,
    output logic [mer_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import mer_pkg::*;

    logic [RADIUS_BITS-1:0]         radius_x;
    logic [RADIUS_BITS-1:0]         radius_y;
    logic signed [COORD_BITS-1:0]   center_x;
    logic signed [COORD_BITS-1:0]   center_y;
    t_dp_cmd                        dp_cmd;
    t_dp_stat                       dp_stat;
    logic                           emit_free;
    logic [RADIUS_BITS:0]           step_x;
    logic [RADIUS_BITS+1:0]         step_y;

    mer_regs #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_radius_x (radius_x),
        .o_radius_y (radius_y),
        .o_center_x (center_x),
        .o_center_y (center_y)
    );

    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_restart   (i_restart),
        .o_ready     (o_ready),
        .i_stat      (dp_stat),
        .i_emit_free (emit_free),
        .o_cmd       (dp_cmd)
    );

    mer_dpath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_radius_x (radius_x),
        .i_radius_y (radius_y),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_step_x   (step_x),
        .o_step_y   (step_y)
    );

    mer_emit #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_step_x   (step_x),
        .i_step_y   (step_y),
        .i_center_x (center_x),
        .i_center_y (center_y),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_pixel_x  (o_pixel_x),
        .o_pixel_y  (o_pixel_y),
        .o_last     (o_last),
        .o_finished (o_finished),
        .o_free     (emit_free)
    );

endmodule

// ===== rtl/mer_checker.sv =====
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks of the raster core, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mer_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_ready,
    input logic                   o_valid,
    input logic [COORD_BITS:0]    o_pixel_x,
    input logic [COORD_BITS:0]    o_pixel_y,
    input logic                   o_last,
    input logic                   o_finished,
    input logic                   pready
);

    `ASSERT_IMPL(a_fin_beat_shape, o_valid && o_finished, o_last && o_pixel_x == '0 && o_pixel_y == '0)
    `ASSERT_NEXT(a_points_contiguous, o_valid && i_ready && !o_last, o_valid && !o_finished)
    `ASSERT_NEXT(a_stall_holds, o_valid && !i_ready, o_valid && $stable(o_pixel_x) && $stable(o_last))
    `ASSERT_IMPL(a_pready_high, 1'b1, pready)

endmodule

bind midpoint_ellipse_raster_core mer_checker #(.COORD_BITS(COORD_BITS)) u_mer_checker (.*);
